FILE: hw/rtl/stt_pkg.sv
// Shared types and constants for the segment table translator.
// Used by stt_ctrl, stt_datapath and segment_table_translator_unit.
package stt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDRESS_BITS_DEF  = 32;

    localparam int SEG_W    = 8;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 3;
    localparam int PHYS_W   = 33;

    localparam logic CMD_INSERT    = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRANSLATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT_FAULT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic req_load;    // capture the request fields
        logic mem_write;   // append the request to the table
        logic res_insert;  // result: inserted
        logic res_full;    // result: table full
        logic res_missing; // result: segment missing
        logic res_match;   // result: from the entry under compare
        logic out_load;    // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seg_hit;     // entry read last cycle holds the requested segment
    } t_dp_stat;

endpackage

FILE: hw/rtl/stt_ctrl.sv
// Controller for the segment table translator: request FSM, entry count,
// scan index and output valid. Depends on stt_pkg.
module stt_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4,
    parameter int CNT_W         = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  stt_pkg::t_dp_stat i_stat,
    output stt_pkg::t_dp_cmd  o_cmd,
    output logic [IDX_W-1:0]  o_rd_addr,
    output logic [IDX_W-1:0]  o_wr_addr
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_issue, n_issue;
    logic             r_chk, n_chk;
    logic             r_chk_last, n_chk_last;
    logic             r_out_valid, n_out_valid;

    logic accept;
    logic out_free;
    logic idx_last;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;
    assign idx_last  = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_rd_addr = r_idx;
    assign o_wr_addr = r_count[IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_chk       = r_chk;
        n_chk_last  = r_chk_last;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.req_load = 1'b1;
                    if (i_command == CMD_INSERT) begin
                        if (r_count >= CNT_W'(TABLE_ENTRIES)) begin
                            o_cmd.res_full = 1'b1;
                        end else begin
                            o_cmd.mem_write  = 1'b1;
                            o_cmd.res_insert = 1'b1;
                            n_count          = r_count + CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        o_cmd.res_missing = 1'b1;
                        n_state           = S_DONE;
                    end else begin
                        n_idx      = '0;
                        n_issue    = 1'b1;
                        n_chk      = 1'b0;
                        n_chk_last = 1'b0;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // oldest entry is checked first, so the first hit wins
                if (r_chk && i_stat.seg_hit) begin
                    o_cmd.res_match = 1'b1;
                    n_state         = S_DONE;
                end else if (r_chk && r_chk_last) begin
                    o_cmd.res_missing = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    n_chk      = r_issue;
                    n_chk_last = r_issue && idx_last;
                    if (r_issue) begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_issue = !idx_last;
                    end
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_chk_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_chk_last  <= n_chk_last;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/stt_datapath.sv
// Datapath for the segment table translator: request registers, entry
// memory, segment compare, limit check, adder and output register. Depends on stt_pkg.
module stt_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4,
    parameter int AW            = 32
) (
    input  logic                           i_clk,
    input  stt_pkg::t_dp_cmd               i_cmd,
    input  logic [IDX_W-1:0]               i_rd_addr,
    input  logic [IDX_W-1:0]               i_wr_addr,
    input  logic [stt_pkg::SEG_W-1:0]      i_segment_number,
    input  logic [stt_pkg::FIELD_W-1:0]    i_base_address,
    input  logic [stt_pkg::FIELD_W-1:0]    i_limit_value,
    input  logic [stt_pkg::FIELD_W-1:0]    i_offset_value,
    output stt_pkg::t_dp_stat              o_stat,
    output logic [stt_pkg::STATUS_W-1:0]   o_status,
    output logic [stt_pkg::PHYS_W-1:0]     o_physical_address
);
    import stt_pkg::*;

    logic [SEG_W-1:0] mem_seg   [TABLE_ENTRIES];
    logic [AW-1:0]    mem_base  [TABLE_ENTRIES];
    logic [AW-1:0]    mem_limit [TABLE_ENTRIES];

    logic [SEG_W-1:0]    r_seg;
    logic [AW-1:0]       r_off;
    logic [SEG_W-1:0]    r_rd_seg;
    logic [AW-1:0]       r_rd_base;
    logic [AW-1:0]       r_rd_limit;
    logic [STATUS_W-1:0] r_res_status;
    logic [PHYS_W-1:0]   r_res_phys;
    logic [STATUS_W-1:0] r_out_status;
    logic [PHYS_W-1:0]   r_out_phys;

    logic [AW:0] sum;
    logic        in_limit;

    assign o_stat.seg_hit     = (r_rd_seg == r_seg);
    assign sum                = (AW+1)'(r_rd_base) + (AW+1)'(r_off);
    assign in_limit           = (r_off < r_rd_limit);
    assign o_status           = r_out_status;
    assign o_physical_address = r_out_phys;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            mem_seg[i_wr_addr]   <= i_segment_number;
            mem_base[i_wr_addr]  <= i_base_address[AW-1:0];
            mem_limit[i_wr_addr] <= i_limit_value[AW-1:0];
        end
        r_rd_seg   <= mem_seg[i_rd_addr];
        r_rd_base  <= mem_base[i_rd_addr];
        r_rd_limit <= mem_limit[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_seg <= i_segment_number;
            r_off <= i_offset_value[AW-1:0];
        end

        priority if (i_cmd.res_insert) begin
            r_res_status <= ST_INSERTED;
            r_res_phys   <= '0;
        end else if (i_cmd.res_full) begin
            r_res_status <= ST_FULL;
            r_res_phys   <= '0;
        end else if (i_cmd.res_missing) begin
            r_res_status <= ST_MISSING;
            r_res_phys   <= '0;
        end else if (i_cmd.res_match) begin
            if (in_limit) begin
                r_res_status <= ST_TRANSLATED;
                r_res_phys   <= PHYS_W'(sum);
            end else begin
                r_res_status <= ST_LIMIT_FAULT;
                r_res_phys   <= '0;
            end
        end

        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_phys   <= r_res_phys;
        end
    end

endmodule

FILE: hw/rtl/segment_table_translator_unit.sv
// Segment table translator, top level: instantiates stt_ctrl and stt_datapath.
// Depends on stt_pkg.
//
// Usage:
//   Request channel (i_valid / o_stall) carries i_command with the segment
//   number, base, limit and offset. Insert appends an entry (table full
//   refuses it); translate finds the oldest entry with the segment number
//   and returns base + offset when the offset is below the limit, else a
//   limit fault, or segment missing when no entry matches.
//   Result channel (o_valid / i_stall) carries o_status and o_physical_address,
//   exactly one result per request, in order.
//   Insert, and translate on an empty table, finish without a table scan;
//   any other translate scans from the oldest entry until one matches or
//   all have been checked. The entry memory is scanned one entry per cycle
//   through its registered read port. One request is in work at a time; the
//   next is taken at the edge after the previous result is loaded into the
//   output register.
//   Reset empties the table (entry count to zero) and drops any result.
//   While the receiver stalls, the result is held; one further request is
//   taken and worked, then waits until the output register frees up.
module segment_table_translator_unit #(
    parameter int TABLE_ENTRIES = stt_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = stt_pkg::ADDRESS_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic [stt_pkg::SEG_W-1:0]    i_segment_number,
    input  logic [stt_pkg::FIELD_W-1:0]  i_base_address,
    input  logic [stt_pkg::FIELD_W-1:0]  i_limit_value,
    input  logic [stt_pkg::FIELD_W-1:0]  i_offset_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [stt_pkg::STATUS_W-1:0] o_status,
    output logic [stt_pkg::PHYS_W-1:0]   o_physical_address
);
    import stt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int AW    = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    stt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    stt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .AW            (AW)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_cmd              (dp_cmd),
        .i_rd_addr          (rd_addr),
        .i_wr_addr          (wr_addr),
        .i_segment_number   (i_segment_number),
        .i_base_address     (i_base_address),
        .i_limit_value      (i_limit_value),
        .i_offset_value     (i_offset_value),
        .o_stat             (dp_stat),
        .o_status           (o_status),
        .o_physical_address (o_physical_address)
    );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for segment_table_translator_unit: directed and random
// insert/translate requests checked against an in-bench segment table predictor.
// Depends on stt_pkg and the RTL of segment_table_translator_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int NUM_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_REQUESTS = 1800;

    typedef struct {
        logic               cmd;
        logic [SEG_W-1:0]   seg;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] limit;
        logic [FIELD_W-1:0] offset;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PHYS_W-1:0]   phys;
    } t_translation;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_command;
    logic [SEG_W-1:0]    i_segment_number;
    logic [FIELD_W-1:0]  i_base_address;
    logic [FIELD_W-1:0]  i_limit_value;
    logic [FIELD_W-1:0]  i_offset_value;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [PHYS_W-1:0]   o_physical_address;

    // Predicted segment table.
    int                 seg_count;
    logic [SEG_W-1:0]   seg_number [NUM_ENTRIES];
    logic [FIELD_W-1:0] seg_base   [NUM_ENTRIES];
    logic [FIELD_W-1:0] seg_bound  [NUM_ENTRIES];

    t_translation expected_results [$];
    int           error_count;
    int           cycle_count;
    bit           idle_on;

    segment_table_translator_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_segment_number   (i_segment_number),
        .i_base_address     (i_base_address),
        .i_limit_value      (i_limit_value),
        .i_offset_value     (i_offset_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_physical_address (o_physical_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    // Mostly short idle runs, a few long ones.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // Apply one request to the predicted table and return its result.
    function automatic t_translation apply_request(t_request rq);
        t_translation res;
        bit found;
        res.status = ST_MISSING;
        res.phys   = '0;
        found      = 1'b0;
        if (rq.cmd == CMD_INSERT) begin
            if (seg_count >= NUM_ENTRIES) begin
                res.status = ST_FULL;
            end else begin
                seg_number[seg_count] = rq.seg;
                seg_base[seg_count]   = rq.base;
                seg_bound[seg_count]  = rq.limit;
                seg_count++;
                res.status = ST_INSERTED;
            end
        end else begin
            // oldest matching entry wins
            for (int k = 0; k < seg_count; k++) begin
                if (!found && seg_number[k] == rq.seg) begin
                    found = 1'b1;
                    if (rq.offset < seg_bound[k]) begin
                        res.status = ST_TRANSLATED;
                        res.phys   = {1'b0, seg_base[k]} + {1'b0, rq.offset};
                    end else begin
                        res.status = ST_LIMIT_FAULT;
                    end
                end
            end
        end
        return res;
    endfunction

    // Called right after the clock rises; returns right after the request is accepted.
    task automatic send_request(input t_request rq);
        int gap;
        gap = (idle_on && $urandom_range(0, 1) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_command        <= rq.cmd;
        i_segment_number <= rq.seg;
        i_base_address   <= rq.base;
        i_limit_value    <= rq.limit;
        i_offset_value   <= rq.offset;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(apply_request(rq));
    endtask

    task automatic send_fields(input logic cmd, input logic [SEG_W-1:0] seg,
                               input logic [FIELD_W-1:0] base,
                               input logic [FIELD_W-1:0] limit,
                               input logic [FIELD_W-1:0] offset);
        t_request rq;
        rq.cmd    = cmd;
        rq.seg    = seg;
        rq.base   = base;
        rq.limit  = limit;
        rq.offset = offset;
        send_request(rq);
    endtask

    // Result checker: compare each accepted result with the oldest prediction.
    initial begin
        t_translation exp_res;
        error_count = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d address 0x%0h",
                             $time, o_status, o_physical_address);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, o_status);
                        error_count++;
                    end
                    if (o_physical_address !== exp_res.phys) begin
                        $display("%0t: physical_address expected 0x%0h actual 0x%0h",
                                 $time, exp_res.phys, o_physical_address);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver back-pressure: free runs, with stalled runs between them while idle_on is set.
    initial begin
        int  run_len;
        bit  hold;
        run_len = 0;
        hold    = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_len == 0) begin
                if (!hold && idle_on && $urandom_range(0, 2) == 0) begin
                    hold    = 1'b1;
                    run_len = idle_length();
                end else begin
                    hold    = 1'b0;
                    run_len = $urandom_range(1, 8);
                end
            end
            run_len--;
            i_stall <= hold && idle_on;
        end
    end

    task automatic test_empty_lookup();
        send_fields(CMD_TRANSLATE, 8'h00, '0, '0, '0);
        send_fields(CMD_TRANSLATE, 8'hFF, '1, '1, '1);
    endtask

    task automatic test_limit_boundaries();
        // zero limit always faults
        send_fields(CMD_INSERT, 8'h00, 32'h0, 32'h0, 32'h0);
        send_fields(CMD_TRANSLATE, 8'h00, '0, '0, 32'h0);
        // carry out of the sum lands in bit 32
        send_fields(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_fields(CMD_TRANSLATE, 8'hFF, '0, '0, 32'hFFFF_FFFE);
        send_fields(CMD_TRANSLATE, 8'hFF, '0, '0, 32'hFFFF_FFFF);
        send_fields(CMD_INSERT, 8'h80, 32'h1234_5678, 32'h0000_0100, 32'h0);
        send_fields(CMD_TRANSLATE, 8'h80, '0, '0, 32'h0000_00FF);
        send_fields(CMD_TRANSLATE, 8'h80, '0, '0, 32'h0000_0100);
        send_fields(CMD_TRANSLATE, 8'h80, '0, '0, 32'h0);
    endtask

    task automatic test_duplicate_segments();
        // second entry for segment FF must never be used
        send_fields(CMD_INSERT, 8'hFF, 32'h0000_1000, 32'h0000_0010, 32'h0);
        send_fields(CMD_TRANSLATE, 8'hFF, '0, '0, 32'h0000_0020);
        send_fields(CMD_INSERT, 8'h5A, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
        send_fields(CMD_TRANSLATE, 8'h5A, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554);
        send_fields(CMD_TRANSLATE, 8'h5B, '0, '0, 32'h0);
    endtask

    task automatic test_random_mix(input int count);
        t_request       rq;
        int             k;
        int             insert_pct;
        logic [FIELD_W-1:0] lim;
        for (int n = 0; n < count; n++) begin
            // first stretch runs without any idling
            idle_on    = (n >= 150);
            insert_pct = (seg_count < NUM_ENTRIES) ? 4 : 6;
            rq.base    = $urandom;
            rq.limit   = $urandom;
            rq.offset  = $urandom;
            if ($urandom_range(0, 99) < insert_pct) begin
                rq.cmd = CMD_INSERT;
                if (seg_count > 0 && $urandom_range(0, 2) == 0) begin
                    rq.seg = seg_number[$urandom_range(0, seg_count - 1)];
                end else begin
                    rq.seg = SEG_W'($urandom_range(0, 255));
                end
                case ($urandom_range(0, 4))
                    0: rq.limit = '0;
                    1: rq.limit = $urandom_range(1, 64);
                    2: rq.limit = '1;
                    default: ;
                endcase
            end else begin
                rq.cmd = CMD_TRANSLATE;
                if (seg_count > 0 && $urandom_range(0, 9) < 8) begin
                    k      = $urandom_range(0, seg_count - 1);
                    rq.seg = seg_number[k];
                    lim    = seg_bound[k];
                    case ($urandom_range(0, 5))
                        0: rq.offset = lim;
                        1: rq.offset = lim - 1;
                        2: rq.offset = (lim == 0) ? '0 : $urandom % lim;
                        3: rq.offset = lim + $urandom_range(1, 16);
                        default: ;
                    endcase
                end else begin
                    rq.seg = SEG_W'($urandom_range(0, 255));
                end
            end
            send_request(rq);
        end
    endtask

    initial begin
        idle_on          = 1'b1;
        seg_count        = 0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_command        <= CMD_INSERT;
        i_segment_number <= '0;
        i_base_address   <= '0;
        i_limit_value    <= '0;
        i_offset_value   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookup();
        test_limit_boundaries();
        test_duplicate_segments();
        test_random_mix(RANDOM_REQUESTS);

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (NUM_ENTRIES + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
